// File: sv/rss_pkg.sv
`timescale 1ns / 1ps
// rss_pkg: shared types and constants for running_sample_statistics
// no dependencies

package rss_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int THRESH_BITS = 15;
    localparam int COUNT_BITS  = 17;
    localparam int TOTAL_BITS  = 32;
    localparam int SQ_BITS     = 47;
    localparam int OUT_BITS    = 16;

    typedef enum logic [3:0] {
        ST_ACC  = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_ROOT = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    typedef struct packed {
        logic acc_en;
        logic div_start;
        logic div_step;
        logic root_start;
        logic root_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic set_end;
        logic div_done;
        logic root_done;
    } status_t;

endpackage

// File: sv/rss_ctrl.sv
`timescale 1ns / 1ps
// rss_ctrl: controller state machine for running_sample_statistics
// depends on rss_pkg

module rss_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  rss_pkg::status_t  status,
    output rss_pkg::cmd_t     cmd
);

    rss_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        in_stall       = 1'b1;
        unique case (state_reg)
            rss_pkg::ST_ACC:
            begin
                in_stall   = 1'b0;
                cmd.acc_en = in_valid;
                if (in_valid && status.set_end)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = rss_pkg::ST_DIV;
                end
            end
            rss_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    cmd.root_start = 1'b1;
                    state_next     = rss_pkg::ST_ROOT;
                end
            end
            rss_pkg::ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (status.root_done)
                    state_next = rss_pkg::ST_OUT;
            end
            rss_pkg::ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = rss_pkg::ST_ACC;
                end
            end
            default: state_next = rss_pkg::ST_ACC;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rss_pkg::ST_ACC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: sv/rss_datapath.sv
`timescale 1ns / 1ps
// rss_datapath: accumulators, serial dividers, serial square root, result registers
// depends on rss_pkg

module rss_datapath #(
    parameter int MAX_SAMPLES = 65536
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [rss_pkg::THRESH_BITS-1:0]        threshold,
    input  logic signed [15:0]                     sample,
    input  logic                                   last_sample,
    input  rss_pkg::cmd_t                          cmd,
    output rss_pkg::status_t                       status,
    output logic [rss_pkg::COUNT_BITS-1:0]         sample_count,
    output logic signed [rss_pkg::TOTAL_BITS-1:0]  total,
    output logic [rss_pkg::SQ_BITS-1:0]            total_of_squares,
    output logic signed [15:0]                     smallest,
    output logic signed [15:0]                     largest,
    output logic signed [15:0]                     mean,
    output logic [15:0]                            deviation,
    output logic [rss_pkg::COUNT_BITS-1:0]         nonzero_count
);

    localparam int SAMPLE_BITS = rss_pkg::SAMPLE_BITS;
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int SW = SAMPLE_BITS + CW + 1;
    localparam int QW = 2 * SAMPLE_BITS + CW;
    localparam int MW = SAMPLE_BITS + 1;
    localparam int DW = (SW > QW) ? SW : QW;
    localparam int DCW = $clog2(DW + 2);
    localparam int RW = (QW + 1) / 2;
    localparam int VW = 2 * RW;
    localparam int RCW = $clog2(RW + 2);
    localparam logic signed [SAMPLE_BITS-1:0] MOST_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [SAMPLE_BITS-1:0] s;
    logic [SAMPLE_BITS-1:0]        mag;
    logic [2*SAMPLE_BITS-1:0]      sq;
    logic [CW-1:0]                 cnt_inc;

    logic [CW-1:0]                 cnt_reg;
    logic signed [SW-1:0]          sum_reg;
    logic [QW-1:0]                 sq_reg;
    logic signed [SAMPLE_BITS-1:0] min_reg, max_reg;
    logic [CW-1:0]                 nz_reg;

    logic [CW-1:0]                 f_cnt_reg, f_nz_reg;
    logic signed [SW-1:0]          f_sum_reg;
    logic [QW-1:0]                 f_sq_reg;
    logic signed [SAMPLE_BITS-1:0] f_min_reg, f_max_reg;

    logic [DW-1:0]   mq_reg, qq_reg;
    logic [DW:0]     mr_reg, qr_reg;
    logic [DCW-1:0]  dcnt_reg;
    logic            neg_reg;
    logic [DW:0]     mr_sh, qr_sh, mr_sub, qr_sub;
    logic [DW-1:0]   abs_sum;
    logic [MW-1:0]   mean_mag;
    logic [2*MW-1:0] meansq_reg;

    logic [VW-1:0]   rv_reg;
    logic [RW-1:0]   root_reg;
    logic [QW+1:0]   rrem_reg;
    logic [RCW-1:0]  rcnt_reg;
    logic [QW+1:0]   rtrial, rrem_sh;
    logic signed [MW:0] mean_s;

    assign s       = SAMPLE_BITS'(sample);
    assign mag     = s[SAMPLE_BITS-1] ? SAMPLE_BITS'(-s) : SAMPLE_BITS'(s);
    assign sq      = mag * mag;
    assign cnt_inc = cnt_reg + CW'(1);
    assign status.set_end = last_sample || (32'(cnt_inc) >= 32'(MAX_SAMPLES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            sum_reg <= '0;
            sq_reg  <= '0;
            min_reg <= MOST_POS;
            max_reg <= MOST_NEG;
            nz_reg  <= '0;
        end
        else if (cmd.acc_en)
        begin
            if (status.set_end)
            begin
                cnt_reg <= '0;
                sum_reg <= '0;
                sq_reg  <= '0;
                min_reg <= MOST_POS;
                max_reg <= MOST_NEG;
                nz_reg  <= '0;
            end
            else
            begin
                cnt_reg <= cnt_inc;
                sum_reg <= sum_reg + SW'(s);
                sq_reg  <= sq_reg + QW'(sq);
                if (s < min_reg)
                    min_reg <= s;
                if (s > max_reg)
                    max_reg <= s;
                if (32'(mag) > 32'(threshold))
                    nz_reg <= nz_reg + CW'(1);
            end
        end
    end

    // final values of the set
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            f_cnt_reg <= cnt_inc;
            f_sum_reg <= sum_reg + SW'(s);
            f_sq_reg  <= sq_reg + QW'(sq);
            f_min_reg <= (s < min_reg) ? s : min_reg;
            f_max_reg <= (s > max_reg) ? s : max_reg;
            f_nz_reg  <= (32'(mag) > 32'(threshold)) ? nz_reg + CW'(1) : nz_reg;
        end
    end

    // two restoring dividers, one quotient bit per cycle
    assign abs_sum = f_sum_reg[SW-1] ? DW'(-f_sum_reg) : DW'(f_sum_reg);
    assign mr_sh   = {mr_reg[DW-1:0], mq_reg[DW-1]};
    assign qr_sh   = {qr_reg[DW-1:0], qq_reg[DW-1]};
    assign mr_sub  = mr_sh - (DW+1)'(f_cnt_reg);
    assign qr_sub  = qr_sh - (DW+1)'(f_cnt_reg);
    assign mean_mag = MW'(mq_reg);
    assign status.div_done = (dcnt_reg == DCW'(DW + 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dcnt_reg <= '0;
        else if (cmd.div_start)
            dcnt_reg <= '0;
        else if (cmd.div_step && !status.div_done)
            dcnt_reg <= dcnt_reg + DCW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_step && dcnt_reg == '0)
        begin
            mq_reg  <= abs_sum;
            qq_reg  <= DW'(f_sq_reg);
            mr_reg  <= '0;
            qr_reg  <= '0;
            neg_reg <= f_sum_reg[SW-1];
        end
        else if (cmd.div_step && !status.div_done)
        begin
            if (!mr_sub[DW])
            begin
                mr_reg <= mr_sub;
                mq_reg <= {mq_reg[DW-2:0], 1'b1};
            end
            else
            begin
                mr_reg <= mr_sh;
                mq_reg <= {mq_reg[DW-2:0], 1'b0};
            end
            if (!qr_sub[DW])
            begin
                qr_reg <= qr_sub;
                qq_reg <= {qq_reg[DW-2:0], 1'b1};
            end
            else
            begin
                qr_reg <= qr_sh;
                qq_reg <= {qq_reg[DW-2:0], 1'b0};
            end
        end
    end

    // square root, one result bit per cycle
    assign rrem_sh = {rrem_reg[QW-1:0], rv_reg[VW-1:VW-2]};
    assign rtrial  = rrem_sh - (QW+2)'({root_reg, 2'b01});
    assign status.root_done = (rcnt_reg == RCW'(RW + 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rcnt_reg <= '0;
        else if (cmd.root_start)
            rcnt_reg <= '0;
        else if (cmd.root_step && !status.root_done)
            rcnt_reg <= rcnt_reg + RCW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.root_start)
        begin
            meansq_reg <= mean_mag * mean_mag;
        end
        if (cmd.root_step && rcnt_reg == '0)
        begin
            rv_reg   <= (QW'(meansq_reg) > QW'(qq_reg)) ? '0
                        : VW'(QW'(qq_reg) - QW'(meansq_reg));
            root_reg <= '0;
            rrem_reg <= '0;
        end
        else if (cmd.root_step && !status.root_done)
        begin
            rv_reg <= {rv_reg[VW-3:0], 2'b00};
            if (!rtrial[QW+1])
            begin
                rrem_reg <= rtrial;
                root_reg <= {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rrem_reg <= rrem_sh;
                root_reg <= {root_reg[RW-2:0], 1'b0};
            end
        end
    end

    assign mean_s = neg_reg ? -$signed({1'b0, mean_mag}) : $signed({1'b0, mean_mag});

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            sample_count     <= rss_pkg::COUNT_BITS'(f_cnt_reg);
            total            <= rss_pkg::TOTAL_BITS'(f_sum_reg);
            total_of_squares <= rss_pkg::SQ_BITS'(f_sq_reg);
            smallest         <= 16'(f_min_reg);
            largest          <= 16'(f_max_reg);
            mean             <= 16'(mean_s);
            deviation        <= 16'(root_reg);
            nonzero_count    <= rss_pkg::COUNT_BITS'(f_nz_reg);
        end
    end

endmodule

// File: sv/running_sample_statistics.sv
`timescale 1ns / 1ps
// running_sample_statistics: top level, controller plus datapath
// depends on rss_pkg, rss_ctrl, rss_datapath
//
// channel   direction  handshake            payload
// in        input      in_valid/in_stall    sample, last_sample
// out       output     out_valid/out_stall  sample_count .. nonzero_count
// cfg       input      cfg_valid/cfg_ready  cfg_data (nonzero_threshold)
//
// one sample per cycle while a set is open
// a set end stalls input while the DW-bit dividers run, then the RW-bit square root, where
// DW = 2*SAMPLE_BITS + clog2(MAX_SAMPLES + 1) and RW = (DW + 1) / 2:
// one bit per cycle in the dividers, then one root bit per cycle
// input is stalled from set end until the result sits in the output register
// reset clears the accumulators and the threshold

module running_sample_statistics #(
    parameter int MAX_SAMPLES = 65536
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [15:0]                    sample,
    input  logic                                  last_sample,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [rss_pkg::COUNT_BITS-1:0]        sample_count,
    output logic signed [rss_pkg::TOTAL_BITS-1:0] total,
    output logic [rss_pkg::SQ_BITS-1:0]           total_of_squares,
    output logic signed [15:0]                    smallest,
    output logic signed [15:0]                    largest,
    output logic signed [15:0]                    mean,
    output logic [15:0]                           deviation,
    output logic [rss_pkg::COUNT_BITS-1:0]        nonzero_count,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rss_pkg::THRESH_BITS-1:0]       cfg_data
);

    rss_pkg::cmd_t    cmd;
    rss_pkg::status_t status;
    logic [rss_pkg::THRESH_BITS-1:0] thresh_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thresh_reg <= '0;
        else if (cfg_valid)
            thresh_reg <= cfg_data;
    end

    rss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    rss_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .threshold        (thresh_reg),
        .sample           (sample),
        .last_sample      (last_sample),
        .cmd              (cmd),
        .status           (status),
        .sample_count     (sample_count),
        .total            (total),
        .total_of_squares (total_of_squares),
        .smallest         (smallest),
        .largest          (largest),
        .mean             (mean),
        .deviation        (deviation),
        .nonzero_count    (nonzero_count)
    );

endmodule
